// ===== design/rcfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rcfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h20;

  // normalization: (raw - 1500) * 16384 / 500, saturated to +-16384
  localparam logic signed [16:0] NORM_CENTER = 17'sd1500;
  localparam logic signed [16:0] NORM_SPAN   = 17'sd500;
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

  // floor(x * 4096 / 125) == (x * RECIP) >> RECIP_SHIFT for x < 500
  localparam int          RECIP_W     = 22;
  localparam logic [21:0] RECIP       = 22'd2147484;
  localparam int          RECIP_SHIFT = 16;
  localparam int          ABS_W       = 9;
  localparam int          PROD_W      = 31;

  // command handed from the front to the back for each finished frame
  typedef struct packed {
    logic ok;
    logic bank;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/rcfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcfd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/rcfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcfd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rcfd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               q_valid,
  output rcfd_pkg::cmd_t     q_cmd
);

  rcfd_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign q_valid = (count != 2'd0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != 2'd0))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== design/rcfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcfd_front #(
  parameter int FRAME_BYTES = 32,
  parameter int ADDR_W      = $clog2(2 * FRAME_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data,
  output logic                   push,
  output rcfd_pkg::cmd_t         push_cmd,
  input  wire logic              back_done
);

  localparam int POS_W = $clog2(FRAME_BYTES);

  logic [POS_W-1:0] pos;
  logic [15:0]      sum;
  logic [7:0]       prev_byte;
  logic             bank;
  logic [1:0]       pend;     // frames handed over and not yet fully emitted

  logic accept;
  logic idle;
  logic take;
  logic at_end;

  // two banks: a third frame would overwrite the one still being read
  assign in_ready = (pend != 2'd2);
  assign accept   = in_valid && in_ready;
  assign idle     = (pos == '0);
  assign take     = accept && (!idle || (data_byte == rcfd_pkg::HEADER_BYTE));
  assign at_end   = (pos == POS_W'(FRAME_BYTES - 1));

  assign wr_en   = take;
  assign wr_data = data_byte;
  assign wr_addr = bank ? (ADDR_W'(FRAME_BYTES) + ADDR_W'(pos)) : ADDR_W'(pos);

  assign push          = take && at_end;
  assign push_cmd.ok   = ({data_byte, prev_byte} == ~sum);
  assign push_cmd.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      sum  <= 16'd0;
      bank <= 1'b0;
      pend <= 2'd0;
    end else begin
      if (take) begin
        if (at_end) begin
          pos  <= '0;
          bank <= ~bank;
        end else begin
          pos <= pos + POS_W'(1);
        end
        if (idle) begin
          sum <= {8'h00, data_byte};
        end else if (pos < POS_W'(FRAME_BYTES - 2)) begin
          sum <= sum + {8'h00, data_byte};
        end
      end
      case ({push, back_done})
        2'b10:   pend <= pend + 2'd1;
        2'b01:   pend <= pend - 2'd1;
        default: pend <= pend;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_byte <= data_byte;
    end
  end

`ifndef SYNTHESIS
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("pending frame count out of range");
  a_done_has_pend: assert property (@(posedge clk) disable iff (rst)
    back_done |-> (pend != 2'd0))
    else $error("frame finished with none pending");
`endif

endmodule
`default_nettype wire

// ===== design/rcfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rcfd_back #(
  parameter int FRAME_BYTES  = 32,
  parameter int MAX_CHANNELS = 14,
  parameter int ADDR_W       = $clog2(2 * FRAME_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire rcfd_pkg::cmd_t    q_cmd,
  output logic                   pop,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   back_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   frame_ok,
  output logic      [3:0]        channel_index,
  output logic      [15:0]       raw_width,
  output logic signed [15:0]     normalized,
  output logic                   last
);

  localparam int POS_W    = $clog2(FRAME_BYTES);
  localparam int CH_LIMIT = (FRAME_BYTES - 4) / 2;
  localparam int CH_COUNT = (MAX_CHANNELS < CH_LIMIT) ? MAX_CHANNELS : CH_LIMIT;
  localparam int CH_W     = (CH_COUNT > 1) ? $clog2(CH_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_CALC,
    S_MUL,
    S_EMIT
  } state_t;

  state_t                            state;
  logic                              ok;
  logic                              bank;
  logic [POS_W-1:0]                  off;
  logic [CH_W-1:0]                   chan;
  logic [7:0]                        raw_lo;
  logic [15:0]                       raw;
  logic                              sat_pos;
  logic                              sat_neg;
  logic                              neg;
  logic [rcfd_pkg::ABS_W-1:0]        abs_d;
  logic [rcfd_pkg::PROD_W-1:0]       prod;

  logic [POS_W-1:0]      rd_off;
  logic [15:0]           raw_full;
  logic signed [16:0]    diff;
  logic signed [16:0]    diff_abs;
  logic signed [15:0]    quot;
  logic signed [15:0]    norm_val;
  logic                  out_free;
  logic                  chan_last;
  logic [CH_W+3:0]       chan_ext;

  assign rd_off  = (state == S_HI) ? (off + POS_W'(1)) : off;
  assign rd_addr = bank ? (ADDR_W'(FRAME_BYTES) + ADDR_W'(rd_off)) : ADDR_W'(rd_off);

  assign raw_full = {rd_data, raw_lo};
  assign diff     = $signed({1'b0, raw_full}) - rcfd_pkg::NORM_CENTER;
  assign diff_abs = diff[16] ? -diff : diff;

  assign quot = $signed({1'b0, prod[rcfd_pkg::PROD_W-1:rcfd_pkg::RECIP_SHIFT]});

  always_comb begin
    if (sat_pos) begin
      norm_val = rcfd_pkg::Q14_ONE;
    end else if (sat_neg) begin
      norm_val = -rcfd_pkg::Q14_ONE;
    end else if (neg) begin
      norm_val = -quot;
    end else begin
      norm_val = quot;
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign chan_last = (chan == CH_W'(CH_COUNT - 1));
  assign chan_ext  = {4'h0, chan};
  assign pop       = (state == S_IDLE) && q_valid;
  assign back_done = (state == S_EMIT) && out_free && (!ok || chan_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_EMIT the register is either held or reloaded below
      if (out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            ok   <= q_cmd.ok;
            bank <= q_cmd.bank;
            off  <= POS_W'(2);
            chan <= '0;
            state <= q_cmd.ok ? S_LO : S_EMIT;
          end
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          raw_lo <= rd_data;
          state  <= S_CALC;
        end
        S_CALC: begin
          raw     <= raw_full;
          sat_pos <= (diff >= rcfd_pkg::NORM_SPAN);
          sat_neg <= (diff <= -rcfd_pkg::NORM_SPAN);
          neg     <= diff[16];
          abs_d   <= diff_abs[rcfd_pkg::ABS_W-1:0];
          state   <= S_MUL;
        end
        S_MUL: begin
          prod  <= rcfd_pkg::PROD_W'(abs_d) * rcfd_pkg::PROD_W'(rcfd_pkg::RECIP);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (ok) begin
              frame_ok      <= 1'b1;
              channel_index <= chan_ext[3:0];
              raw_width     <= raw;
              normalized    <= norm_val;
              last          <= chan_last;
              if (chan_last) begin
                state <= S_IDLE;
              end else begin
                chan  <= chan + CH_W'(1);
                off   <= off + POS_W'(2);
                state <= S_LO;
              end
            end else begin
              frame_ok      <= 1'b0;
              channel_index <= 4'd0;
              raw_width     <= 16'd0;
              normalized    <= 16'sd0;
              last          <= 1'b1;
              state         <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((normalized >= -rcfd_pkg::Q14_ONE) && (normalized <= rcfd_pkg::Q14_ONE)))
    else $error("normalized value out of range");
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_ok) |-> (last && (channel_index == 4'd0) && (raw_width == 16'd0)))
    else $error("rejection result malformed");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE))
    else $error("command taken but back stayed idle");
`endif

endmodule
`default_nettype wire

// ===== design/rc_serial_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rc serial frame decoder
// input channel (in_valid/in_ready/data_byte): one received serial byte per item.
//   bytes are dropped until the header 0x20 starts a frame of FRAME_BYTES bytes;
//   each byte taken is written straight into a two-bank frame store.
// output channel (out_valid/out_ready/frame_ok/channel_index/raw_width/
//   normalized/last): after the last byte of a frame, a good checksum gives one
//   item per channel with last on the final one, a bad checksum one item with
//   frame_ok low and last high.
// order: after the last byte of a frame its command passes the queue; per channel the
//   back end does two reads through the frame store's one read port, the normalize compare
//   and multiply steps, then emits the item before it starts on the next channel.
// a short command queue sits between the byte front end and the result back
//   end, so the next frame streams in while the previous one is emitted.
// the front end holds in_ready low only when two frames are waiting to be
//   emitted (both store banks in use).
// a stalled receiver holds the output register; the back end waits behind it
//   and the front end keeps taking bytes until both banks are filled.
// reset (rst, synchronous) returns to hunting for a header and empties the
//   queue; the frame store needs no clearing.
module rc_serial_frame_decoder #(
  parameter int FRAME_BYTES  = 32,
  parameter int MAX_CHANNELS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [3:0]       channel_index,
  output logic [15:0]      raw_width,
  output logic signed [15:0] normalized,
  output logic             last
);

  // two banks of FRAME_BYTES bytes each
  localparam int DEPTH  = 2 * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              push;
  rcfd_pkg::cmd_t    push_cmd;
  logic              pop;
  logic              q_valid;
  rcfd_pkg::cmd_t    q_cmd;
  logic              back_done;

  // byte collection, running sum and checksum check
  rcfd_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .back_done (back_done)
  );

  // frame store
  rcfd_ram #(
    .WIDTH  (8),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // finished-frame commands
  rcfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // channel readout and normalization
  rcfd_back #(
    .FRAME_BYTES  (FRAME_BYTES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .back_done     (back_done),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_ok      (frame_ok),
    .channel_index (channel_index),
    .raw_width     (raw_width),
    .normalized    (normalized),
    .last          (last)
  );

endmodule
`default_nettype wire
